@@ src/lzced_pkg.sv @@
// Package: sizes, codes and constants of the LoG zero-crossing edge detector.
`default_nettype none
package lzced_pkg;

  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int MAX_MASK  = 9;

  localparam int FRAME_CAP = MAX_ROWS * MAX_COLS;
  localparam int MASK_CAP  = MAX_MASK * MAX_MASK;
  localparam int ADDR_W    = $clog2(FRAME_CAP);
  localparam int CNT_W     = $clog2(FRAME_CAP + 1);
  localparam int RIDX_W    = $clog2(MAX_ROWS);
  localparam int CIDX_W    = $clog2(MAX_COLS);
  localparam int MASK_AW   = $clog2(MASK_CAP + 1);
  localparam int MSZ_W     = 4;
  localparam int DIM_W     = 9;
  localparam int RESP_W    = 24;
  localparam int DIV_W     = RESP_W + 8;
  localparam int GSUM_W    = 15;
  localparam int REC_W     = 13;
  localparam int REC_SH    = 19;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MSIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_HI = 3'd4;

  localparam logic [1:0] CMD_COEF  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_FETCH = 2'd2;

  localparam logic [1:0] CLS_MINUS = 2'd0;
  localparam logic [1:0] CLS_ZERO  = 2'd1;
  localparam logic [1:0] CLS_PLUS  = 2'd2;

  localparam logic [7:0] LEVEL_MINUS = 8'd64;
  localparam logic [7:0] LEVEL_ZERO  = 8'd128;
  localparam logic [7:0] LEVEL_PLUS  = 8'd192;
  localparam logic [7:0] EDGE_NONE   = 8'd255;
  localparam logic [7:0] EDGE_MARK   = 8'd0;

  // gray = (21r + 72g + 7b) / 100, the divide as * 5243 >> 19 (exact below 43699)
  localparam logic [GSUM_W-1:0] W_RED   = 15'd21;
  localparam logic [GSUM_W-1:0] W_GREEN = 15'd72;
  localparam logic [GSUM_W-1:0] W_BLUE  = 15'd7;
  localparam logic [REC_W-1:0]  REC_100 = 13'd5243;

  localparam logic [DIM_W-1:0] RST_ROWS  = 9'd256;
  localparam logic [DIM_W-1:0] RST_COLS  = 9'd256;
  localparam logic [MSZ_W-1:0] RST_MSIZE = 4'd9;
  localparam logic [7:0]       RST_THR_LO = 8'd118;
  localparam logic [7:0]       RST_THR_HI = 8'd147;

endpackage
`default_nettype wire

@@ src/lzced_if.sv @@
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none
interface lzced_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic signed [7:0] coefficient;

  modport source (output valid, command, red, green, blue, coefficient, input ready);
  modport sink   (input valid, command, red, green, blue, coefficient, output ready);
endinterface

interface lzced_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] scaled_response;
  logic [7:0] class_level;
  logic [7:0] edge_value;
  logic       last;

  modport source (output valid, scaled_response, class_level, edge_value, last, input ready);
  modport sink   (input valid, scaled_response, class_level, edge_value, last, output ready);
endinterface
`default_nettype wire

@@ src/log_zero_crossing_edge_detector.sv @@
// Top level: LoG zero-crossing edge detector over frame memories.
// Coefficients are written to the mask memory as they are accepted. Pixel load: the gray
// write is pipelined behind accept. After the final pixel, the frame is convolved
// through the single MAC, then each response is scaled (8-step divider per pixel).
// Fetch reads the 9-pixel neighbourhood of interior class-zero pixels.
// Synchronous reset clears control state; memories are not cleared.
`default_nettype none
module log_zero_crossing_edge_detector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lzced_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lzced_pkg::CFG_DATA_W-1:0] cfg_data,
  lzced_req_if.sink                        request,
  lzced_res_if.source                      result
);
  import lzced_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_PIX    = 13'b0000000000010,
    S_CONV   = 13'b0000000000100,
    S_DRAIN  = 13'b0000000001000,
    S_SC_RD  = 13'b0000000010000,
    S_SC_LD  = 13'b0000000100000,
    S_SC_DIV = 13'b0000001000000,
    S_SC_WR  = 13'b0000010000000,
    S_F_RD   = 13'b0000100000000,
    S_F_CHK  = 13'b0001000000000,
    S_NB_RD  = 13'b0010000000000,
    S_NB_CHK = 13'b0100000000000,
    S_F_OUT  = 13'b1000000000000
  } state_t;

  state_t state;

  // configuration
  logic [DIM_W-1:0] rows_cfg, cols_cfg;
  logic [MSZ_W-1:0] msize_cfg;
  logic [7:0]       thr_lo, thr_hi;

  // control
  logic [MASK_AW-1:0] coef_cnt;
  logic [CNT_W-1:0]   pix_cnt, rd_ptr, total_r;
  logic               frame_ready;
  logic [DIM_W-1:0]   fr_rows, fr_cols;
  logic [MSZ_W-1:0]   fm;
  logic [MASK_AW-1:0] fmm;
  logic signed [RESP_W-1:0] rmin, rmax;

  // pixel load
  logic [GSUM_W-1:0] pix_sum;
  logic [ADDR_W-1:0] pix_addr;
  logic              pix_store, pix_done;

  // convolution
  logic [RIDX_W-1:0]  ci;
  logic [CIDX_W-1:0]  cj;
  logic [MSZ_W-1:0]   cp, cq;
  logic [MASK_AW-1:0] ctap;
  logic [ADDR_W-1:0]  cpix;
  logic               p1_v, p1_first, p1_last;
  logic [ADDR_W-1:0]  p1_idx;
  logic               p2_v;
  logic [ADDR_W-1:0]  p2_idx;
  logic signed [RESP_W-1:0] acc;
  logic [7:0]         gray_q;
  logic signed [7:0]  coef_q;

  // scaling
  logic [CNT_W-1:0]  sk;
  logic signed [RESP_W-1:0] resp_q;
  logic [RESP_W-1:0] dreg;
  logic [DIV_W-1:0]  rem;
  logic [7:0]        quo;
  logic [2:0]        qbit;

  // fetch
  logic [RIDX_W-1:0] frow;
  logic [CIDX_W-1:0] fcol;
  logic [9:0]        sc_q;
  logic [7:0]        f_s;
  logic [1:0]        f_cls;
  logic              f_edge;
  logic [ADDR_W-1:0] nb_addr;
  logic [1:0]        ndr, ndc;

  // output register
  logic       res_valid;
  logic [7:0] res_scaled, res_class, res_edge;
  logic       res_last;

  // memories
  logic signed [7:0] mask_mem [MASK_CAP];
  logic [7:0]        gray_mem [FRAME_CAP];
  logic [RESP_W-1:0] resp_mem [FRAME_CAP];
  logic [9:0]        sc_mem   [FRAME_CAP];

  // combinational
  logic               req_acc, out_free;
  logic [DIM_W-1:0]   eff_rows, eff_cols;
  logic [MSZ_W-1:0]   eff_m;
  logic [7:0]         mm_prod;
  logic [MASK_AW-1:0] mm_now, mask_wa, mask_ra;
  logic [2*DIM_W-1:0] total_prod;
  logic [CNT_W-1:0]   total_now;
  logic               mask_we;
  logic [GSUM_W-1:0]  wsum_now;
  logic [GSUM_W+REC_W-1:0] gprod;
  logic [7:0]         gray_val;
  logic [RIDX_W-1:0]  rr;
  logic [CIDX_W-1:0]  cc;
  logic [RIDX_W+DIM_W-1:0] row_base;
  logic [ADDR_W-1:0]  gaddr;
  logic signed [16:0] prod;
  logic               last_tap, last_q, last_pix;
  logic [RESP_W:0]    ndiff;
  logic [DIV_W-1:0]   dsh;
  logic [1:0]         q_cls;
  logic               interior, f_last;
  logic [ADDR_W-1:0]  sc_ra, sk_addr;

  assign req_acc  = request.valid && request.ready;
  assign request.ready = (state == S_IDLE);
  assign out_free = !res_valid || result.ready;

  always_comb begin
    if (rows_cfg < DIM_W'(3)) eff_rows = DIM_W'(3);
    else if (int'(rows_cfg) > MAX_ROWS) eff_rows = DIM_W'(MAX_ROWS);
    else eff_rows = rows_cfg;
    if (cols_cfg < DIM_W'(3)) eff_cols = DIM_W'(3);
    else if (int'(cols_cfg) > MAX_COLS) eff_cols = DIM_W'(MAX_COLS);
    else eff_cols = cols_cfg;
    if (msize_cfg == '0) eff_m = MSZ_W'(1);
    else if (int'(msize_cfg) > MAX_MASK) eff_m = MSZ_W'(MAX_MASK);
    else eff_m = msize_cfg;
    if (!eff_m[0]) eff_m = eff_m - MSZ_W'(1);
  end

  assign mm_prod    = {4'b0, eff_m} * {4'b0, eff_m};
  assign mm_now     = MASK_AW'(mm_prod);
  assign total_prod = eff_rows * eff_cols;
  assign total_now  = CNT_W'(total_prod);

  assign mask_we = req_acc && (request.command == CMD_COEF);
  assign mask_wa = (coef_cnt >= mm_now) ? '0 : coef_cnt;
  assign mask_ra = fmm - MASK_AW'(1) - ctap;

  assign wsum_now = {7'd0, request.red} * W_RED + {7'd0, request.green} * W_GREEN
                  + {7'd0, request.blue} * W_BLUE;
  assign gprod    = pix_sum * REC_100;
  assign gray_val = gprod[REC_SH+7:REC_SH];

  // edge-clamped tap coordinates
  always_comb begin
    int row_i, col_i;
    row_i = int'(ci) + int'(cp) - int'(fm >> 1);
    col_i = int'(cj) + int'(cq) - int'(fm >> 1);
    if (row_i < 0) rr = '0;
    else if (row_i > int'(fr_rows) - 1) rr = RIDX_W'(fr_rows - DIM_W'(1));
    else rr = RIDX_W'(row_i);
    if (col_i < 0) cc = '0;
    else if (col_i > int'(fr_cols) - 1) cc = CIDX_W'(fr_cols - DIM_W'(1));
    else cc = CIDX_W'(col_i);
  end

  assign row_base = rr * fr_cols;
  assign gaddr    = row_base[ADDR_W-1:0] + ADDR_W'(cc);
  assign prod     = $signed({1'b0, gray_q}) * coef_q;

  assign last_tap = (ctap == fmm - MASK_AW'(1));
  assign last_q   = (cq == fm - MSZ_W'(1));
  assign last_pix = (DIM_W'(ci) == fr_rows - DIM_W'(1)) && (DIM_W'(cj) == fr_cols - DIM_W'(1));

  assign ndiff = {resp_q[RESP_W-1], resp_q} - {rmin[RESP_W-1], rmin};
  assign dsh   = DIV_W'(dreg) << qbit;

  always_comb begin
    if (quo <= thr_lo) q_cls = CLS_MINUS;
    else if (quo <= thr_hi) q_cls = CLS_ZERO;
    else q_cls = CLS_PLUS;
  end

  assign interior = (frow != '0) && (DIM_W'(frow) + DIM_W'(1) < fr_rows)
                 && (fcol != '0) && (DIM_W'(fcol) + DIM_W'(1) < fr_cols);
  assign f_last   = (rd_ptr + CNT_W'(1) >= total_r);
  assign sk_addr  = sk[ADDR_W-1:0];
  assign sc_ra    = (state == S_NB_RD) ? nb_addr : rd_ptr[ADDR_W-1:0];

  // memories
  always_ff @(posedge clk) begin
    if (mask_we) mask_mem[mask_wa] <= request.coefficient;
    coef_q <= mask_mem[mask_ra];
  end

  always_ff @(posedge clk) begin
    if (state == S_PIX && pix_store) gray_mem[pix_addr] <= gray_val;
    gray_q <= gray_mem[gaddr];
  end

  always_ff @(posedge clk) begin
    if (p2_v) resp_mem[p2_idx] <= acc;
    resp_q <= resp_mem[sk_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_SC_WR) sc_mem[sk_addr] <= {quo, q_cls};
    sc_q <= sc_mem[sc_ra];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg  <= RST_ROWS;
      cols_cfg  <= RST_COLS;
      msize_cfg <= RST_MSIZE;
      thr_lo    <= RST_THR_LO;
      thr_hi    <= RST_THR_HI;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS:   rows_cfg  <= cfg_data;
        REG_COLS:   cols_cfg  <= cfg_data;
        REG_MSIZE:  msize_cfg <= cfg_data[MSZ_W-1:0];
        REG_THR_LO: thr_lo    <= cfg_data[7:0];
        REG_THR_HI: thr_hi    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // MAC pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= (state == S_CONV);
      p2_v <= p1_v && p1_last;
    end
    p1_first <= (ctap == '0);
    p1_last  <= last_tap;
    p1_idx   <= cpix;
    p2_idx   <= p1_idx;
    if (p1_v) acc <= (p1_first ? '0 : acc) + RESP_W'(prod);
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      coef_cnt    <= '0;
      pix_cnt     <= '0;
      rd_ptr      <= '0;
      frame_ready <= 1'b0;
      rmin        <= '0;
      rmax        <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (res_valid && result.ready && !(state == S_F_OUT && out_free)) res_valid <= 1'b0;

      if (p2_v) begin
        if (p2_idx == '0) begin
          rmin <= acc;
          rmax <= acc;
        end else begin
          if (acc < rmin) rmin <= acc;
          if (acc > rmax) rmax <= acc;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            unique case (request.command)
              CMD_COEF: begin
                coef_cnt <= (mask_wa + MASK_AW'(1) >= mm_now) ? '0 : mask_wa + MASK_AW'(1);
              end
              CMD_PIXEL: begin
                if (!frame_ready) begin
                  pix_store <= (pix_cnt < total_now);
                  pix_done  <= (pix_cnt + CNT_W'(pix_cnt < total_now) >= total_now);
                  pix_sum   <= wsum_now;
                  pix_addr  <= pix_cnt[ADDR_W-1:0];
                  if (pix_cnt < total_now) pix_cnt <= pix_cnt + CNT_W'(1);
                  fr_rows   <= eff_rows;
                  fr_cols   <= eff_cols;
                  fm        <= eff_m;
                  fmm       <= mm_now;
                  total_r   <= total_now;
                  state     <= S_PIX;
                end
              end
              CMD_FETCH: begin
                if (frame_ready) state <= S_F_RD;
              end
              default: ;
            endcase
          end
        end
        S_PIX: begin
          if (pix_done) begin
            ci    <= '0;
            cj    <= '0;
            cp    <= '0;
            cq    <= '0;
            ctap  <= '0;
            cpix  <= '0;
            state <= S_CONV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CONV: begin
          if (last_tap) begin
            ctap <= '0;
            cp   <= '0;
            cq   <= '0;
            cpix <= cpix + ADDR_W'(1);
            if (last_pix) begin
              state <= S_DRAIN;
            end else if (DIM_W'(cj) == fr_cols - DIM_W'(1)) begin
              cj <= '0;
              ci <= ci + RIDX_W'(1);
            end else begin
              cj <= cj + CIDX_W'(1);
            end
          end else begin
            ctap <= ctap + MASK_AW'(1);
            if (last_q) begin
              cq <= '0;
              cp <= cp + MSZ_W'(1);
            end else begin
              cq <= cq + MSZ_W'(1);
            end
          end
        end
        S_DRAIN: begin
          if (!p1_v && !p2_v) begin
            dreg  <= RESP_W'(rmax - rmin);
            sk    <= '0;
            state <= S_SC_RD;
          end
        end
        S_SC_RD: state <= S_SC_LD;
        S_SC_LD: begin
          quo  <= '0;
          qbit <= 3'd7;
          rem  <= {ndiff[RESP_W-1:0], 8'd0} - DIV_W'(ndiff[RESP_W-1:0]);
          state <= (dreg == '0) ? S_SC_WR : S_SC_DIV;
        end
        S_SC_DIV: begin
          if (rem >= dsh) begin
            rem       <= rem - dsh;
            quo[qbit] <= 1'b1;
          end
          if (qbit == '0) state <= S_SC_WR;
          else qbit <= qbit - 3'd1;
        end
        S_SC_WR: begin
          if (sk == total_r - CNT_W'(1)) begin
            frame_ready <= 1'b1;
            rd_ptr      <= '0;
            frow        <= '0;
            fcol        <= '0;
            state       <= S_IDLE;
          end else begin
            sk    <= sk + CNT_W'(1);
            state <= S_SC_RD;
          end
        end
        S_F_RD: state <= S_F_CHK;
        S_F_CHK: begin
          f_s    <= sc_q[9:2];
          f_cls  <= sc_q[1:0];
          f_edge <= 1'b0;
          if (sc_q[1:0] == CLS_ZERO && interior) begin
            nb_addr <= rd_ptr[ADDR_W-1:0] - ADDR_W'(fr_cols) - ADDR_W'(1);
            ndr     <= '0;
            ndc     <= '0;
            state   <= S_NB_RD;
          end else begin
            state <= S_F_OUT;
          end
        end
        S_NB_RD: state <= S_NB_CHK;
        S_NB_CHK: begin
          if (sc_q[1:0] != CLS_ZERO) f_edge <= 1'b1;
          if (ndr == 2'd2 && ndc == 2'd2) begin
            state <= S_F_OUT;
          end else begin
            if (ndc == 2'd2) begin
              ndc     <= '0;
              ndr     <= ndr + 2'd1;
              nb_addr <= nb_addr + ADDR_W'(fr_cols) - ADDR_W'(2);
            end else begin
              ndc     <= ndc + 2'd1;
              nb_addr <= nb_addr + ADDR_W'(1);
            end
            state <= S_NB_RD;
          end
        end
        S_F_OUT: begin
          if (out_free) begin
            res_valid <= 1'b1;
            if (f_last) begin
              rd_ptr      <= '0;
              pix_cnt     <= '0;
              frame_ready <= 1'b0;
            end else begin
              rd_ptr <= rd_ptr + CNT_W'(1);
              if (DIM_W'(fcol) == fr_cols - DIM_W'(1)) begin
                fcol <= '0;
                frow <= frow + RIDX_W'(1);
              end else begin
                fcol <= fcol + CIDX_W'(1);
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_F_OUT && out_free) begin
      res_scaled <= f_s;
      unique case (f_cls)
        CLS_MINUS: res_class <= LEVEL_MINUS;
        CLS_ZERO:  res_class <= LEVEL_ZERO;
        default:   res_class <= LEVEL_PLUS;
      endcase
      res_edge <= f_edge ? EDGE_MARK : EDGE_NONE;
      res_last <= f_last;
    end
  end

  assign result.valid           = res_valid;
  assign result.scaled_response = res_scaled;
  assign result.class_level     = res_class;
  assign result.edge_value      = res_edge;
  assign result.last            = res_last;

endmodule
`default_nettype wire

@@ src/lzced_check.sv @@
// Checker: port-level assertions on the edge detector, bound to the top level.
`default_nettype none
module lzced_check (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_command,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_last,
  input logic [7:0] res_edge
);
  import lzced_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_last) && $stable(res_edge))
    else $error("stalled result changed");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !res_valid && req_ready)
    else $error("not idle after reset");

  a_coef_single: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == CMD_COEF |=> req_ready)
    else $error("coefficient load stalled the request channel");

endmodule

bind log_zero_crossing_edge_detector lzced_check u_lzced_check (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .req_command (request.command),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_last    (result.last),
  .res_edge    (result.edge_value)
);
`default_nettype wire

@@ dv/tb_log_zero_crossing_edge_detector.sv @@
// Testbench: LoG zero-crossing edge detector, directed table then random frames vs predictor.
module tb_log_zero_crossing_edge_detector;
  import lzced_pkg::*;

  localparam logic [1:0] CMD_RSVD = 2'd3;

  typedef struct packed {
    logic [7:0] scaled;
    logic [7:0] level;
    logic [7:0] edge_v;
    logic       last;
  } result_t;

  typedef struct {
    logic [1:0]        cmd;
    logic [7:0]        r, g, b;
    logic signed [7:0] coef;
    bit                typed;
    result_t           exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lzced_req_if req_if ();
  lzced_res_if res_if ();

  log_zero_crossing_edge_detector DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .request(req_if), .result(res_if)
  );

  // predictor state
  int unsigned reg_rows, reg_cols, reg_msize, reg_lo, reg_hi;
  logic signed [7:0] mask_mem [MASK_CAP];
  byte unsigned      gray_mem [FRAME_CAP];
  int                resp_mem [FRAME_CAP];
  logic [1:0]        cls_mem  [FRAME_CAP];
  int unsigned coef_cnt, pix_cnt, rd_ptr, fr_rows, fr_cols;
  int          resp_min, resp_max;
  bit          frame_ready;

  result_t expected_q[$];
  int      errors = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned mask_side();
    int unsigned m;
    m = reg_msize;
    if (m < 1) m = 1;
    if (m > MAX_MASK) m = MAX_MASK;
    if ((m & 1) == 0) m = m - 1;
    return m;
  endfunction

  function automatic logic [7:0] scale_resp(int resp);
    longint d, n;
    d = longint'(resp_max) - longint'(resp_min);
    n = longint'(resp) - longint'(resp_min);
    if (d <= 0 || n < 0) return 8'd0;
    return 8'((n * 255) / d);
  endfunction

  function automatic void convolve_frame();
    int unsigned m, mm, l;
    int h, i, j, p, q, rr, cc, sum;
    logic [7:0] s;
    m = mask_side();
    mm = m * m;
    h = m / 2;
    for (i = 0; i < fr_rows; i++) begin
      for (j = 0; j < fr_cols; j++) begin
        sum = 0;
        l = 0;
        for (p = -h; p <= h; p++) begin
          for (q = -h; q <= h; q++) begin
            rr = i + p; cc = j + q;
            if (rr < 0) rr = 0;
            if (rr > fr_rows - 1) rr = fr_rows - 1;
            if (cc < 0) cc = 0;
            if (cc > fr_cols - 1) cc = fr_cols - 1;
            sum += int'(gray_mem[rr * fr_cols + cc]) * int'(mask_mem[mm - 1 - l]);
            l++;
          end
        end
        resp_mem[i * fr_cols + j] = sum;
        if ((i == 0 && j == 0) || sum < resp_min) resp_min = sum;
        if ((i == 0 && j == 0) || sum > resp_max) resp_max = sum;
      end
    end
    for (i = 0; i < fr_rows * fr_cols; i++) begin
      s = scale_resp(resp_mem[i]);
      cls_mem[i] = (s <= reg_lo) ? CLS_MINUS : ((s <= reg_hi) ? CLS_ZERO : CLS_PLUS);
    end
  endfunction

  function automatic void predict_item(logic [1:0] cmd, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b, logic signed [7:0] cf);
    int unsigned mm, tot, idx, rr, cc, dr, dc;
    result_t res;
    case (cmd)
      CMD_COEF: begin
        mm = mask_side() * mask_side();
        if (coef_cnt >= mm) coef_cnt = 0;
        mask_mem[coef_cnt] = cf;
        coef_cnt++;
        if (coef_cnt >= mm) coef_cnt = 0;
      end
      CMD_PIXEL: begin
        tot = clamp_dim(reg_rows, MAX_ROWS) * clamp_dim(reg_cols, MAX_COLS);
        if (!frame_ready) begin
          if (pix_cnt < tot) begin
            gray_mem[pix_cnt] = 8'((21 * int'(r) + 72 * int'(g) + 7 * int'(b)) / 100);
            pix_cnt++;
          end
          if (pix_cnt >= tot) begin
            fr_rows = clamp_dim(reg_rows, MAX_ROWS);
            fr_cols = clamp_dim(reg_cols, MAX_COLS);
            convolve_frame();
            frame_ready = 1'b1;
            rd_ptr = 0;
          end
        end
      end
      CMD_FETCH: begin
        if (frame_ready) begin
          tot = fr_rows * fr_cols;
          idx = (rd_ptr >= tot) ? tot - 1 : rd_ptr;
          rr = idx / fr_cols; cc = idx % fr_cols;
          res.edge_v = EDGE_NONE;
          if (cls_mem[idx] == CLS_ZERO && rr >= 1 && rr + 1 < fr_rows && cc >= 1 &&
              cc + 1 < fr_cols) begin
            for (dr = 0; dr < 3; dr++)
              for (dc = 0; dc < 3; dc++)
                if (cls_mem[(rr + dr - 1) * fr_cols + cc + dc - 1] != CLS_ZERO)
                  res.edge_v = EDGE_MARK;
          end
          res.scaled = scale_resp(resp_mem[idx]);
          res.level = (cls_mem[idx] == CLS_MINUS) ? LEVEL_MINUS :
                      ((cls_mem[idx] == CLS_ZERO) ? LEVEL_ZERO : LEVEL_PLUS);
          res.last = (idx + 1 >= tot);
          expected_q.push_back(res);
          if (res.last) begin
            rd_ptr = 0; pix_cnt = 0; frame_ready = 1'b0;
          end else begin
            rd_ptr = idx + 1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.scaled_response, res_if.class_level, res_if.edge_value, res_if.last};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.scaled !== want.scaled) begin
            $display("%0t: scaled_response expected %0d actual %0d", $time, want.scaled,
                     got.scaled);
            errors++;
          end
          if (got.level !== want.level) begin
            $display("%0t: class_level expected %0d actual %0d", $time, want.level, got.level);
            errors++;
          end
          if (got.edge_v !== want.edge_v) begin
            $display("%0t: edge_value expected %0d actual %0d", $time, want.edge_v, got.edge_v);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            errors++;
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic signed [7:0] cf);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.red <= r;
    req_if.green <= g;
    req_if.blue <= b;
    req_if.coefficient <= cf;
    do @(posedge clk); while (!req_if.ready);
    predict_item(cmd, r, g, b, cf);
  endtask

  task automatic hold(int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
    req_if.valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROWS:   reg_rows = v & 9'h1FF;
      REG_COLS:   reg_cols = v & 9'h1FF;
      REG_MSIZE:  reg_msize = v & 4'hF;
      REG_THR_LO: reg_lo = v & 8'hFF;
      REG_THR_HI: reg_hi = v & 8'hFF;
      default: ;
    endcase
  endtask

  function automatic logic signed [7:0] rand_coef();
    case ($urandom_range(5))
      0: return -8'sd128;
      1: return 8'sd127;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic run_frame(int unsigned rv, int unsigned cv, int unsigned mv, int unsigned lo,
                           int unsigned hi, bit shrink, bit pause);
    int unsigned tot, k, mm, n;
    logic [7:0] pr, pg, pb;
    logic [7:0] c0 [3];
    logic [7:0] c1 [3];
    write_reg(REG_ROWS, rv);
    write_reg(REG_COLS, cv);
    write_reg(REG_MSIZE, mv);
    write_reg(REG_THR_LO, lo);
    write_reg(REG_THR_HI, hi);
    mm = mask_side() * mask_side();
    for (k = 0; k < mm; k++) send_item(CMD_COEF, rnd8(), rnd8(), rnd8(), rand_coef());
    for (k = 0; k < 3; k++) begin
      c0[k] = rnd8(); c1[k] = rnd8();
    end
    tot = clamp_dim(reg_rows, MAX_ROWS) * clamp_dim(reg_cols, MAX_COLS);
    n = shrink ? tot - clamp_dim(reg_cols, MAX_COLS) : tot;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0: send_item(CMD_FETCH, rnd8(), rnd8(), rnd8(), rnd8());
        1: send_item(CMD_RSVD, rnd8(), rnd8(), rnd8(), rnd8());
        2: send_item(CMD_COEF, rnd8(), rnd8(), rnd8(), rand_coef());
        default: ;
      endcase
      if ($urandom_range(3) == 0) begin
        pr = rnd8(); pg = rnd8(); pb = rnd8();
      end else if ($urandom_range(1) == 0) begin
        pr = c0[0]; pg = c0[1]; pb = c0[2];
      end else begin
        pr = c1[0]; pg = c1[1]; pb = c1[2];
      end
      send_item(CMD_PIXEL, pr, pg, pb, rnd8());
    end
    if (shrink) begin
      // frame shrinks under a partly loaded frame; next pixel is dropped
      hold(10);
      write_reg(REG_ROWS, clamp_dim(reg_rows, MAX_ROWS) - 1);
      send_item(CMD_PIXEL, rnd8(), rnd8(), rnd8(), rnd8());
      tot = clamp_dim(reg_rows, MAX_ROWS) * clamp_dim(reg_cols, MAX_COLS);
    end
    for (k = 0; k < tot; k++) begin
      if (pause && k == tot / 2) drain();
      case ($urandom_range(11))
        0: send_item(CMD_PIXEL, rnd8(), rnd8(), rnd8(), rnd8());
        1: send_item(CMD_RSVD, rnd8(), rnd8(), rnd8(), rnd8());
        default: ;
      endcase
      send_item(CMD_FETCH, rnd8(), rnd8(), rnd8(), rnd8());
    end
    drain();
    hold(10);
  endtask

  stim_row_t dir_tab[$];

  initial begin
    stim_row_t row;
    int f;
    rst = 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    req_if.valid <= 1'b0;
    req_if.command <= CMD_COEF;
    req_if.red <= '0;
    req_if.green <= '0;
    req_if.blue <= '0;
    req_if.coefficient <= '0;
    reg_rows = RST_ROWS; reg_cols = RST_COLS; reg_msize = RST_MSIZE;
    reg_lo = RST_THR_LO; reg_hi = RST_THR_HI;
    coef_cnt = 0; pix_cnt = 0; rd_ptr = 0; resp_min = 0; resp_max = 0;
    frame_ready = 1'b0; fr_rows = 3; fr_cols = 3;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fetch before any frame, reserved command, then a flat white frame
    // (max equals min, so every pixel is scaled 0, class minus one)
    write_reg(REG_ROWS, 3);
    write_reg(REG_COLS, 3);
    write_reg(REG_MSIZE, 1);
    row = '{CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'sd0, 1'b0, '0};
    dir_tab.push_back(row);
    row.cmd = CMD_RSVD;
    dir_tab.push_back(row);
    row = '{CMD_COEF, 8'd0, 8'd0, 8'd0, 8'sd127, 1'b0, '0};
    dir_tab.push_back(row);
    for (f = 0; f < 9; f++) begin
      row = '{CMD_PIXEL, 8'd255, 8'd255, 8'd255, 8'sd0, 1'b0, '0};
      dir_tab.push_back(row);
    end
    row = '{CMD_PIXEL, 8'd0, 8'd0, 8'd0, -8'sd128, 1'b0, '0};
    dir_tab.push_back(row);
    for (f = 0; f < 9; f++) begin
      row = '{CMD_FETCH, 8'd0, 8'd0, 8'd0, 8'sd0, 1'b1,
              '{8'd0, LEVEL_MINUS, EDGE_NONE, (f == 8)}};
      dir_tab.push_back(row);
    end
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].cmd, dir_tab[i].r, dir_tab[i].g, dir_tab[i].b, dir_tab[i].coef);
      if (dir_tab[i].typed) begin
        void'(expected_q.pop_back());
        expected_q.push_back(dir_tab[i].exp);
      end
    end
    drain();
    hold(10);

    for (f = 0; f < 12; f++) begin
      case (f % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      if (f % 7 == 0)
        run_frame($urandom_range(5), $urandom_range(5), $urandom_range(15), 0, 255,
                  1'b0, 1'b1);
      else if (f % 7 == 1)
        run_frame($urandom_range(5), $urandom_range(5), $urandom_range(15), 255, 0,
                  1'b0, 1'b0);
      else if (f % 5 == 2)
        run_frame($urandom_range(4, 6), $urandom_range(3, 5), $urandom_range(15),
                  $urandom_range(255), $urandom_range(255), 1'b1, 1'b0);
      else begin
        k_lo_hi(f);
      end
    end

    drain();
    hold(200);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // random frame with thresholds around the middle, where zero-crossings show up
  task automatic k_lo_hi(int f);
    int unsigned lo;
    lo = $urandom_range(40, 160);
    run_frame($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(15), lo,
              lo + $urandom_range(0, 90), 1'b0, (f % 3 == 0));
  endtask

endmodule
